### hw/rtl/prf_pkg.sv
// shared command and status types for the pollard rho divisor search
`timescale 1ns / 1ps
`default_nettype none

package prf_pkg;

    // controller to datapath commands
    typedef struct packed {
        logic load;        // capture a new number
        logic mul_start;   // load the serial multiplier
        logic mul_src;     // 0: slow value, 1: fast value
        logic mul_step;    // one multiplier bit
        logic mul_fin;     // add one and write back to the source value
        logic gcd_load;    // load gcd operands
        logic gcd_step;    // one binary gcd step
        logic shift_step;  // undo one common factor of two
        logic emit;        // present the result word
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic m_small;     // number below two
        logic mul_last;    // last multiplier bit in progress
        logic gcd_done;    // gcd operand a reached zero
        logic k_zero;      // no common factors of two left
        logic g_one;       // gcd equals one
        logic out_free;    // output register can take a word
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/prf_datapath.sv
// datapath: serial modular squaring, binary gcd and output register
`timescale 1ns / 1ps
`default_nettype none

module prf_datapath #(
    parameter int WIDTH = 31
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [WIDTH-1:0]  number,
    input  wire prf_pkg::cmd_t     cmd,
    output prf_pkg::sts_t          sts,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [WIDTH-1:0]       divisor,
    output logic                   found
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] m_reg, slow_reg, fast_reg, ma_reg, mb_reg, acc_reg;
    logic [WIDTH-1:0] ga_reg, gb_reg, divisor_reg;
    logic [CW-1:0]    cnt_reg, gk_reg;
    logic             found_reg, out_valid_reg;

    logic [WIDTH:0]   dbl, sum, inc;
    logic [WIDTH-1:0] dr, acc_next, fin_val, diff, init_val;

    always_comb
    begin
        dbl      = {acc_reg, 1'b0};
        dr       = (dbl >= {1'b0, m_reg}) ? WIDTH'(dbl - {1'b0, m_reg}) : dbl[WIDTH-1:0];
        sum      = {1'b0, dr} + (mb_reg[WIDTH-1] ? {1'b0, ma_reg} : '0);
        acc_next = (sum >= {1'b0, m_reg}) ? WIDTH'(sum - {1'b0, m_reg}) : sum[WIDTH-1:0];
        inc      = {1'b0, acc_reg} + (WIDTH+1)'(1);
        fin_val  = (inc == {1'b0, m_reg}) ? '0 : inc[WIDTH-1:0];
        diff     = (fast_reg >= slow_reg) ? fast_reg - slow_reg : slow_reg - fast_reg;
        // with a modulus of two the start value 2 reduces to 0
        init_val = (number == WIDTH'(2)) ? '0 : WIDTH'(2);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_reg    <= number;
            slow_reg <= init_val;
            fast_reg <= init_val;
        end
        if (cmd.mul_start)
        begin
            ma_reg  <= cmd.mul_src ? fast_reg : slow_reg;
            mb_reg  <= cmd.mul_src ? fast_reg : slow_reg;
            acc_reg <= '0;
            cnt_reg <= CW'(WIDTH);
        end
        if (cmd.mul_step)
        begin
            acc_reg <= acc_next;
            mb_reg  <= {mb_reg[WIDTH-2:0], 1'b0};
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.mul_fin)
        begin
            if (cmd.mul_src)
                fast_reg <= fin_val;
            else
                slow_reg <= fin_val;
        end
        if (cmd.load)
        begin
            gb_reg <= number;
            gk_reg <= '0;
        end
        if (cmd.gcd_load)
        begin
            ga_reg <= diff;
            gb_reg <= m_reg;
            gk_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            if (!ga_reg[0] && !gb_reg[0])
            begin
                ga_reg <= ga_reg >> 1;
                gb_reg <= gb_reg >> 1;
                gk_reg <= gk_reg + CW'(1);
            end
            else if (!ga_reg[0])
                ga_reg <= ga_reg >> 1;
            else if (!gb_reg[0])
                gb_reg <= gb_reg >> 1;
            else if (ga_reg >= gb_reg)
                ga_reg <= ga_reg - gb_reg;
            else
                gb_reg <= gb_reg - ga_reg;
        end
        if (cmd.shift_step)
        begin
            gb_reg <= gb_reg << 1;
            gk_reg <= gk_reg - CW'(1);
        end
        if (cmd.emit)
        begin
            divisor_reg <= gb_reg;
            found_reg   <= (gb_reg < m_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        // captured number, the input port may already carry the next word
        sts.m_small  = (m_reg < WIDTH'(2));
        sts.mul_last = (cnt_reg == CW'(1));
        sts.gcd_done = (ga_reg == '0);
        sts.k_zero   = (gk_reg == '0);
        sts.g_one    = (gb_reg == WIDTH'(1));
        sts.out_free = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign divisor   = divisor_reg;
    assign found     = found_reg;

endmodule

`default_nettype wire

### hw/rtl/prf_ctrl.sv
// controller state machine sequencing rounds of the divisor search
`timescale 1ns / 1ps
`default_nettype none

module prf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire prf_pkg::sts_t  sts,
    output prf_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LCHK   = 4'd1;
    localparam logic [3:0] S_MSTART = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_FIN    = 4'd4;
    localparam logic [3:0] S_GLOAD  = 4'd5;
    localparam logic [3:0] S_GCD    = 4'd6;
    localparam logic [3:0] S_SHIFT  = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;   // 0: slow step, 1 and 2: fast steps

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cmd           = '0;
        cmd.mul_src   = (phase_reg != 2'd0);
        in_stall      = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LCHK;
                end
            end
            S_LCHK:
            begin
                phase_next = 2'd0;
                state_next = sts.m_small ? S_EMIT : S_MSTART;
            end
            S_MSTART:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.mul_fin = 1'b1;
                if (phase_reg == 2'd2)
                    state_next = S_GLOAD;
                else
                begin
                    phase_next = phase_reg + 2'd1;
                    state_next = S_MSTART;
                end
            end
            S_GLOAD:
            begin
                cmd.gcd_load = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                    state_next = S_SHIFT;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_SHIFT:
            begin
                if (!sts.k_zero)
                    cmd.shift_step = 1'b1;
                else if (sts.g_one)
                begin
                    phase_next = 2'd0;
                    state_next = S_MSTART;
                end
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pollard_rho_factor.sv
// top level of the pollard rho divisor search
//
// input channel: number with in_valid / in_stall; one word is taken when
// in_valid is high and in_stall low. the block works on one number at a time
// and holds in_stall high from acceptance until its result is handed to the
// output register.
// output channel: divisor and found with out_valid / out_stall. the result
// word sits in an output register, so a new number is taken while a
// finished word still waits for the receiver.
// rounds: each round runs three modular squarings, one on the slow value and
// two on the fast value, on one shift-add multiplier, then a binary gcd
// of their difference with the number and a shift back for each common
// factor of two; the number of rounds depends on the data. numbers below
// two skip the rounds and go from the check state to the emit state.
// reset clears the controller and the output valid flag; any search in
// progress is dropped. while out_stall is high, the finished word holds and
// the controller waits before placing the next one.
`timescale 1ns / 1ps
`default_nettype none

module pollard_rho_factor #(
    parameter int WIDTH = 31
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [WIDTH-1:0]  number,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [WIDTH-1:0]       divisor,
    output logic                   found
);

    prf_pkg::cmd_t cmd;
    prf_pkg::sts_t sts;

    // sequencing of rounds, gcd and result hand-off
    prf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // operand registers, serial multiplier, gcd unit, output register
    prf_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .number    (number),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .divisor   (divisor),
        .found     (found)
    );

endmodule

`default_nettype wire
